// ===== design/lpm_pkg.sv =====
// Shared types and constants for the loop period monitor.
package lpm_pkg;

    // Event codes carried in the func field
    localparam logic [1:0] FUNC_WORK    = 2'd0;
    localparam logic [1:0] FUNC_IDLE    = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    // Timing constants in nanoseconds
    localparam logic [29:0] NS_PER_SEC   = 30'd1000000000;
    localparam logic [29:0] MAX_SLEEP_NS = 30'd999999999;
    localparam logic [29:0] HOT_IDLE_NS  = 30'd1000000;

    // Warmup limits in write-attempting cycles
    localparam logic [3:0] MIN_WARM_CYCLES = 4'd2;
    localparam logic [3:0] MAX_WARM_CYCLES = 4'd10;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_PERIOD   = 3'd0;
    localparam logic [2:0] REG_UNDERRUN = 3'd1;
    localparam logic [2:0] REG_OVERRUN  = 3'd2;
    localparam logic [2:0] REG_FORCE    = 3'd3;
    localparam logic [2:0] REG_WARMUP   = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] time_sec;
        logic [29:0] time_nsec;
        logic        clock_ok;
        logic        attempted_write;
    } evt_t;

    typedef struct packed {
        logic signed [30:0] sleep_ns;
        logic               underrun_flag;
        logic               overrun_flag;
        logic [31:0]        underrun_total;
        logic [31:0]        overrun_total;
        logic               warm;
        logic [3:0]         warmup_count;
        logic [31:0]        warmup_sec;
        logic [29:0]        warmup_nsec;
    } res_t;

endpackage

// ===== design/loop_period_monitor.sv =====
// Loop period monitor: warmup tracking, underrun/overrun classing and sleep time.
//
// One event word goes in per software loop pass and one result word comes out
// for each. An accepted word sits in an input register; once the result
// register can take it, the state update and result are formed in a single
// pass of subtract, add and compare logic and land in the result register. A
// new word is taken every cycle while the result side keeps draining. When the
// result register is full and not taken, the input register holds one further
// word before evt_ready drops. Configuration registers sit on an APB port at
// byte addresses 0, 4, 8, 12 and 16 and are to be written by the user only
// while the block is idle; the block itself does not enforce it.
module loop_period_monitor (
    input  logic          clk,
    input  logic          rst_n,
    // event channel
    input  logic          evt_valid,
    output logic          evt_ready,
    input  lpm_pkg::evt_t evt,
    // result channel
    output logic          res_valid,
    input  logic          res_ready,
    output lpm_pkg::res_t res,
    // configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import lpm_pkg::*;

    // Configuration registers
    logic [29:0] period_ns_reg, underrun_ns_reg, overrun_ns_reg, force_ns_reg, warmup_ns_reg;

    // Monitor state
    logic [31:0] prev_sec_reg, prev_sec_next;
    logic [29:0] prev_nsec_reg, prev_nsec_next;
    logic        prev_valid_reg, prev_valid_next;
    logic        is_warmed_reg, is_warmed_next;
    logic [3:0]  warm_cycles_reg, warm_cycles_next;
    logic [31:0] warm_acc_sec_reg, warm_acc_sec_next;
    logic [29:0] warm_acc_nsec_reg, warm_acc_nsec_next;
    logic        skip_overrun_reg, skip_overrun_next;
    logic [31:0] underrun_counter_reg, underrun_counter_next;
    logic [31:0] overrun_counter_reg, overrun_counter_next;

    // Pipeline registers
    evt_t evt_reg;
    logic evt_valid_reg;
    res_t res_reg, res_next;
    logic res_valid_reg;
    logic advance;

    // Delta and helper signals
    logic [29:0]        tnsec;
    logic               borrow;
    logic [30:0]        dnsec_wide;
    logic [29:0]        dnsec;
    logic signed [33:0] dsec;
    logic               dsec_pos;
    logic [30:0]        acc_sum;
    logic               acc_wrap;
    logic [29:0]        acc_nsec_new;
    logic [31:0]        acc_sec_new;
    logic [3:0]         cycles_new;
    logic signed [30:0] period_sleep;
    logic [29:0]        force_diff;
    logic signed [30:0] force_sleep;
    logic               cfg_write;

    // Configuration write and read
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_ns_reg   <= '0;
            underrun_ns_reg <= '0;
            overrun_ns_reg  <= '0;
            force_ns_reg    <= '0;
            warmup_ns_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_PERIOD:   period_ns_reg   <= pwdata[29:0];
                REG_UNDERRUN: underrun_ns_reg <= pwdata[29:0];
                REG_OVERRUN:  overrun_ns_reg  <= pwdata[29:0];
                REG_FORCE:    force_ns_reg    <= pwdata[29:0];
                REG_WARMUP:   warmup_ns_reg   <= pwdata[29:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_PERIOD:   prdata = {2'b00, period_ns_reg};
            REG_UNDERRUN: prdata = {2'b00, underrun_ns_reg};
            REG_OVERRUN:  prdata = {2'b00, overrun_ns_reg};
            REG_FORCE:    prdata = {2'b00, force_ns_reg};
            REG_WARMUP:   prdata = {2'b00, warmup_ns_reg};
            default:      prdata = '0;
        endcase
    end

    // Handshake: advance the held word when the result register can take it
    assign advance   = evt_valid_reg && (!res_valid_reg || res_ready);
    assign evt_ready = !evt_valid_reg || advance;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Clamp the incoming nanoseconds
    assign tnsec = (evt_reg.time_nsec > MAX_SLEEP_NS) ? MAX_SLEEP_NS : evt_reg.time_nsec;

    // Time since the previous stamp, nanoseconds brought into range
    assign borrow     = tnsec < prev_nsec_reg;
    assign dnsec_wide = {1'b0, tnsec} - {1'b0, prev_nsec_reg}
                        + (borrow ? {1'b0, NS_PER_SEC} : 31'd0);
    assign dnsec      = dnsec_wide[29:0];
    assign dsec       = $signed({2'b00, evt_reg.time_sec}) - $signed({2'b00, prev_sec_reg})
                        - $signed({33'd0, borrow});
    assign dsec_pos   = !dsec[33] && (dsec != 34'sd0);

    // Warmup accumulation
    assign acc_sum      = {1'b0, warm_acc_nsec_reg} + {1'b0, dnsec};
    assign acc_wrap     = acc_sum >= {1'b0, NS_PER_SEC};
    assign acc_nsec_new = acc_wrap ? 30'(acc_sum - {1'b0, NS_PER_SEC}) : acc_sum[29:0];
    assign acc_sec_new  = warm_acc_sec_reg + dsec[31:0] + {31'd0, acc_wrap};
    assign cycles_new   = warm_cycles_reg + 4'd1;

    // Sleep candidates, saturated to the legal range
    assign period_sleep = $signed({1'b0,
                          (period_ns_reg > MAX_SLEEP_NS) ? MAX_SLEEP_NS : period_ns_reg});
    assign force_diff   = force_ns_reg - dnsec;
    assign force_sleep  = (force_ns_reg < dnsec) ? -31'sd1 :
                          $signed({1'b0, (force_diff > MAX_SLEEP_NS) ? MAX_SLEEP_NS : force_diff});

    // Next state and result for the held word
    always_comb
    begin
        logic warmed_now;
        logic uflag;
        logic oflag;
        logic signed [30:0] sleep;

        prev_sec_next         = prev_sec_reg;
        prev_nsec_next        = prev_nsec_reg;
        prev_valid_next       = prev_valid_reg;
        is_warmed_next        = is_warmed_reg;
        warm_cycles_next      = warm_cycles_reg;
        warm_acc_sec_next     = warm_acc_sec_reg;
        warm_acc_nsec_next    = warm_acc_nsec_reg;
        skip_overrun_next     = skip_overrun_reg;
        underrun_counter_next = underrun_counter_reg;
        overrun_counter_next  = overrun_counter_reg;
        warmed_now            = is_warmed_reg;
        uflag                 = 1'b0;
        oflag                 = 1'b0;
        sleep                 = $signed({1'b0, MAX_SLEEP_NS});

        case (evt_reg.func)
            FUNC_IDLE:
            begin
                prev_valid_next   = 1'b0;
                skip_overrun_next = 1'b1;
                sleep             = $signed({1'b0, HOT_IDLE_NS});
            end
            FUNC_RESTART:
            begin
                is_warmed_next     = 1'b0;
                warm_acc_sec_next  = '0;
                warm_acc_nsec_next = '0;
                warm_cycles_next   = '0;
                skip_overrun_next  = 1'b1;
                sleep              = -31'sd1;
                prev_valid_next    = evt_reg.clock_ok;
                if (evt_reg.clock_ok)
                begin
                    prev_sec_next  = evt_reg.time_sec;
                    prev_nsec_next = tnsec;
                end
            end
            FUNC_WORK:
            begin
                if (!evt_reg.clock_ok)
                begin
                    prev_valid_next = 1'b0;
                    sleep           = period_sleep;
                end
                else if (!prev_valid_reg)
                begin
                    prev_valid_next   = 1'b1;
                    sleep             = period_sleep;
                    skip_overrun_next = 1'b1;
                    prev_sec_next     = evt_reg.time_sec;
                    prev_nsec_next    = tnsec;
                end
                else
                begin
                    // Accumulate warmup on write-attempting cycles
                    if (!is_warmed_reg && evt_reg.attempted_write)
                    begin
                        warm_acc_sec_next  = acc_sec_new;
                        warm_acc_nsec_next = acc_nsec_new;
                        warm_cycles_next   = cycles_new;
                        if ((dnsec > warmup_ns_reg && cycles_new >= MIN_WARM_CYCLES)
                            || cycles_new >= MAX_WARM_CYCLES)
                            warmed_now = 1'b1;
                    end
                    is_warmed_next = warmed_now;
                    sleep          = -31'sd1;
                    // Class the cycle once warm
                    if (warmed_now)
                    begin
                        if (dsec_pos || dnsec > underrun_ns_reg)
                        begin
                            uflag                 = 1'b1;
                            underrun_counter_next = underrun_counter_reg + 32'd1;
                            skip_overrun_next     = 1'b1;
                        end
                        else if (dnsec < overrun_ns_reg)
                        begin
                            if (skip_overrun_reg)
                                skip_overrun_next = 1'b0;
                            else
                            begin
                                oflag                = 1'b1;
                                overrun_counter_next = overrun_counter_reg + 32'd1;
                            end
                            sleep = force_sleep;
                        end
                        else
                            skip_overrun_next = 1'b0;
                    end
                    prev_sec_next  = evt_reg.time_sec;
                    prev_nsec_next = tnsec;
                end
            end
            default: ;
        endcase

        res_next.sleep_ns       = sleep;
        res_next.underrun_flag  = uflag;
        res_next.overrun_flag   = oflag;
        res_next.underrun_total = underrun_counter_next;
        res_next.overrun_total  = overrun_counter_next;
        res_next.warm           = is_warmed_next;
        res_next.warmup_count   = warm_cycles_next;
        res_next.warmup_sec     = warm_acc_sec_next;
        res_next.warmup_nsec    = warm_acc_nsec_next;
    end

    // Input register: hold one word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            evt_valid_reg <= 1'b0;
        else if (evt_ready)
            evt_valid_reg <= evt_valid;
    end

    always_ff @(posedge clk)
    begin
        if (evt_valid && evt_ready)
            evt_reg <= evt;
    end

    // Result register and state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg        <= 1'b0;
            prev_sec_reg         <= '0;
            prev_nsec_reg        <= '0;
            prev_valid_reg       <= 1'b0;
            is_warmed_reg        <= 1'b0;
            warm_cycles_reg      <= '0;
            warm_acc_sec_reg     <= '0;
            warm_acc_nsec_reg    <= '0;
            skip_overrun_reg     <= 1'b1;
            underrun_counter_reg <= '0;
            overrun_counter_reg  <= '0;
        end
        else if (advance)
        begin
            res_valid_reg        <= 1'b1;
            prev_sec_reg         <= prev_sec_next;
            prev_nsec_reg        <= prev_nsec_next;
            prev_valid_reg       <= prev_valid_next;
            is_warmed_reg        <= is_warmed_next;
            warm_cycles_reg      <= warm_cycles_next;
            warm_acc_sec_reg     <= warm_acc_sec_next;
            warm_acc_nsec_reg    <= warm_acc_nsec_next;
            skip_overrun_reg     <= skip_overrun_next;
            underrun_counter_reg <= underrun_counter_next;
            overrun_counter_reg  <= overrun_counter_next;
        end
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

endmodule

// ===== test/tb_loop_period_monitor.sv =====
// Self-checking testbench for the loop period monitor: directed and random event streams.
`timescale 1ns / 100ps

module tb_loop_period_monitor;
    import lpm_pkg::*;

    // Event code that the block must ignore
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam longint ONE_SEC_NS = 1_000_000_000;
    localparam int MAX_REPORTED = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic evt_valid = 1'b0;
    logic evt_ready;
    evt_t evt = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Predicted state of the monitor, starting from its reset values
    logic [31:0] last_sec = '0;
    logic [29:0] last_nsec = '0;
    bit last_ok;
    bit warmed;
    bit skip_next_over = 1'b1;
    logic [3:0] warm_cnt = '0;
    logic [31:0] warm_sec = '0;
    logic [29:0] warm_nsec = '0;
    logic [31:0] under_cnt = '0;
    logic [31:0] over_cnt = '0;

    // Predicted register contents
    logic [29:0] cfg_period = '0;
    logic [29:0] cfg_under = '0;
    logic [29:0] cfg_over = '0;
    logic [29:0] cfg_force = '0;
    logic [29:0] cfg_warmup = '0;

    res_t pending_results[$];

    // Stimulus timestamp cursor and flow control
    logic [31:0] tick_sec;
    logic [29:0] tick_nsec;
    int burst_left;
    bit steady_flow;
    int rx_run;
    bit rx_open;

    int events_sent;
    int results_checked;
    int mismatches;
    int settings_used;
    int underruns_seen;
    int overruns_seen;
    int warm_results;

    loop_period_monitor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #10 clk = ~clk;

    // Apply one event to the predicted state and form its result word
    function automatic res_t advance_monitor(input evt_t item);
        res_t out_w;
        longint sleep_v;
        longint dsec;
        longint dnsec;
        longint lim;
        logic [29:0] nsec;
        logic [31:0] nsum;
        bit under_hit;
        bit over_hit;
        sleep_v = MAX_SLEEP_NS;
        under_hit = 1'b0;
        over_hit = 1'b0;
        nsec = (item.time_nsec > MAX_SLEEP_NS) ? MAX_SLEEP_NS : item.time_nsec;
        case (item.func)
            FUNC_IDLE:
            begin
                last_ok = 1'b0;
                skip_next_over = 1'b1;
                sleep_v = HOT_IDLE_NS;
            end
            FUNC_RESTART:
            begin
                warmed = 1'b0;
                warm_sec = '0;
                warm_nsec = '0;
                warm_cnt = '0;
                skip_next_over = 1'b1;
                sleep_v = -1;
                last_ok = item.clock_ok;
                if (item.clock_ok)
                begin
                    last_sec = item.time_sec;
                    last_nsec = nsec;
                end
            end
            FUNC_WORK:
            begin
                if (!item.clock_ok)
                begin
                    last_ok = 1'b0;
                    sleep_v = cfg_period;
                end
                else if (!last_ok)
                begin
                    last_ok = 1'b1;
                    sleep_v = cfg_period;
                    skip_next_over = 1'b1;
                    last_sec = item.time_sec;
                    last_nsec = nsec;
                end
                else
                begin
                    // Form the delta with nanoseconds brought into one second
                    dsec = item.time_sec;
                    lim = last_sec;
                    dsec = dsec - lim;
                    dnsec = nsec;
                    lim = last_nsec;
                    dnsec = dnsec - lim;
                    if (dnsec < 0)
                    begin
                        dsec = dsec - 1;
                        dnsec = dnsec + ONE_SEC_NS;
                    end
                    // Accumulate warmup time on write-attempting cycles
                    if (!warmed && item.attempted_write)
                    begin
                        warm_sec = warm_sec + dsec[31:0];
                        nsum = {2'b00, warm_nsec} + dnsec[31:0];
                        if (nsum >= 32'd1_000_000_000)
                        begin
                            warm_sec = warm_sec + 32'd1;
                            nsum = nsum - 32'd1_000_000_000;
                        end
                        warm_nsec = nsum[29:0];
                        warm_cnt = warm_cnt + 4'd1;
                        lim = cfg_warmup;
                        if ((dnsec > lim && warm_cnt >= MIN_WARM_CYCLES)
                            || warm_cnt >= MAX_WARM_CYCLES)
                            warmed = 1'b1;
                    end
                    sleep_v = -1;
                    // Class the cycle once warm
                    if (warmed)
                    begin
                        lim = cfg_under;
                        if (dsec > 0 || dnsec > lim)
                        begin
                            under_hit = 1'b1;
                            under_cnt = under_cnt + 32'd1;
                            skip_next_over = 1'b1;
                        end
                        else
                        begin
                            lim = cfg_over;
                            if (dnsec < lim)
                            begin
                                if (skip_next_over)
                                    skip_next_over = 1'b0;
                                else
                                begin
                                    over_hit = 1'b1;
                                    over_cnt = over_cnt + 32'd1;
                                end
                                lim = cfg_force;
                                sleep_v = lim - dnsec;
                            end
                            else
                                skip_next_over = 1'b0;
                        end
                    end
                    last_sec = item.time_sec;
                    last_nsec = nsec;
                end
            end
            default: ;
        endcase
        // Saturate the sleep time
        lim = MAX_SLEEP_NS;
        if (sleep_v < -1)
            sleep_v = -1;
        else if (sleep_v > lim)
            sleep_v = lim;
        out_w.sleep_ns = sleep_v[30:0];
        out_w.underrun_flag = under_hit;
        out_w.overrun_flag = over_hit;
        out_w.underrun_total = under_cnt;
        out_w.overrun_total = over_cnt;
        out_w.warm = warmed;
        out_w.warmup_count = warm_cnt;
        out_w.warmup_sec = warm_sec;
        out_w.warmup_nsec = warm_nsec;
        return out_w;
    endfunction

    function automatic evt_t make_event(input logic [1:0] f, input logic [31:0] s,
                                        input logic [29:0] ns, input bit ok, input bit wr);
        evt_t item;
        item.func = f;
        item.time_sec = s;
        item.time_nsec = ns;
        item.clock_ok = ok;
        item.attempted_write = wr;
        return item;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTED)
            $display("mismatch on result %0d: %s got 0x%0h, want 0x%0h",
                     results_checked, what, got, want);
    endtask

    // Receiver: alternate runs of ready and stall of random length; steady flow holds ready high
    always @(posedge clk)
    begin
        if (rx_run == 0)
        begin
            rx_open = !rx_open;
            rx_run = rx_open ? $urandom_range(1, 12) : $urandom_range(1, 4);
        end
        rx_run--;
        res_ready <= rx_open || steady_flow;
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no pending event", 64'(res.sleep_ns), '0);
            else
            begin
                want = pending_results.pop_front();
                if (res.sleep_ns !== want.sleep_ns)
                    report_mismatch("sleep_ns", res.sleep_ns, want.sleep_ns);
                if (res.underrun_flag !== want.underrun_flag)
                    report_mismatch("underrun_flag", res.underrun_flag, want.underrun_flag);
                if (res.overrun_flag !== want.overrun_flag)
                    report_mismatch("overrun_flag", res.overrun_flag, want.overrun_flag);
                if (res.underrun_total !== want.underrun_total)
                    report_mismatch("underrun_total", res.underrun_total, want.underrun_total);
                if (res.overrun_total !== want.overrun_total)
                    report_mismatch("overrun_total", res.overrun_total, want.overrun_total);
                if (res.warm !== want.warm)
                    report_mismatch("warm", res.warm, want.warm);
                if (res.warmup_count !== want.warmup_count)
                    report_mismatch("warmup_count", res.warmup_count, want.warmup_count);
                if (res.warmup_sec !== want.warmup_sec)
                    report_mismatch("warmup_sec", res.warmup_sec, want.warmup_sec);
                if (res.warmup_nsec !== want.warmup_nsec)
                    report_mismatch("warmup_nsec", res.warmup_nsec, want.warmup_nsec);
                if (want.underrun_flag)
                    underruns_seen++;
                if (want.overrun_flag)
                    overruns_seen++;
                if (want.warm)
                    warm_results++;
            end
            results_checked++;
        end
    end

    // Send one event word in bursts with random gaps (none under steady flow), predict on acceptance
    task automatic send_event(input evt_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady_flow ? 0 : $urandom_range(0, 5);
            if (gap != 0)
            begin
                evt_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        evt <= item;
        evt_valid <= 1'b1;
        do @(posedge clk); while (!evt_ready);
        pending_results.push_back(advance_monitor(item));
        events_sent++;
    endtask

    // Drop valid and wait until every prediction has been matched
    task automatic settle_block();
        evt_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [29:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {2'($urandom_range(0, 3)), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_PERIOD:   cfg_period = value;
            REG_UNDERRUN: cfg_under = value;
            REG_OVERRUN:  cfg_over = value;
            REG_FORCE:    cfg_force = value;
            REG_WARMUP:   cfg_warmup = value;
            default: ;
        endcase
    endtask

    task automatic program_registers(input logic [29:0] p_period, input logic [29:0] p_under,
                                     input logic [29:0] p_over, input logic [29:0] p_force,
                                     input logic [29:0] p_warmup);
        settle_block();
        write_register(REG_PERIOD, p_period);
        write_register(REG_UNDERRUN, p_under);
        write_register(REG_OVERRUN, p_over);
        write_register(REG_FORCE, p_force);
        write_register(REG_WARMUP, p_warmup);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Move the stimulus timestamp by a signed number of nanoseconds
    task automatic move_cursor(input longint step_ns);
        longint total;
        total = tick_nsec;
        total = total + step_ns;
        while (total >= ONE_SEC_NS)
        begin
            total = total - ONE_SEC_NS;
            tick_sec = tick_sec + 32'd1;
        end
        while (total < 0)
        begin
            total = total + ONE_SEC_NS;
            tick_sec = tick_sec - 32'd1;
        end
        tick_nsec = total[29:0];
    endtask

    task automatic restart_cursor();
        if ($urandom_range(0, 3) == 0)
            tick_sec = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        else
            tick_sec = $urandom();
        tick_nsec = $urandom_range(0, 999_999_999);
    endtask

    // Step sizes clustered round the overrun and underrun thresholds, with some random and some over a second
    function automatic longint pick_delta();
        longint mark;
        case ($urandom_range(0, 9))
            0, 1: mark = $urandom_range(0, cfg_over);
            2:
            begin
                mark = cfg_over;
                mark = mark + $urandom_range(0, 4);
                mark = mark - 2;
            end
            3:
            begin
                mark = cfg_under;
                mark = mark + $urandom_range(0, 4);
                mark = mark - 2;
            end
            4:
            begin
                mark = ONE_SEC_NS;
                mark = mark + $urandom_range(0, 2_000_000_000);
            end
            5: mark = $urandom_range(0, 999_999_999);
            default:
            begin
                if (cfg_under > cfg_over)
                    mark = $urandom_range(cfg_over, cfg_under);
                else
                    mark = $urandom_range(0, cfg_under);
            end
        endcase
        return (mark < 0) ? 0 : mark;
    endfunction

    task automatic send_random_event();
        evt_t item;
        int pick;
        pick = $urandom_range(0, 99);
        item.func = FUNC_WORK;
        item.clock_ok = 1'b1;
        item.attempted_write = ($urandom_range(0, 3) != 0);
        if (pick < 3)
            item.func = FUNC_IDLE;
        else if (pick < 6)
        begin
            item.func = FUNC_RESTART;
            restart_cursor();
            item.clock_ok = ($urandom_range(0, 7) != 0);
        end
        else if (pick < 8)
            item.clock_ok = 1'b0;
        else if (pick < 9)
            item.func = FUNC_UNUSED;
        else if (pick < 11)
            move_cursor(-longint'($urandom_range(0, 5_000_000)));
        else
            move_cursor(pick_delta());
        item.time_sec = tick_sec;
        item.time_nsec = tick_nsec;
        // Timestamps that the block ignores carry noise
        if (pick < 3 || (pick >= 6 && pick < 9))
        begin
            item.time_sec = $urandom();
            item.time_nsec = 30'($urandom());
        end
        // Out-of-range nanoseconds are taken as the top of the range
        if (pick == 11)
        begin
            item.time_nsec = 30'($urandom_range(1_000_000_000, 30'h3FFF_FFFF));
            tick_nsec = MAX_SLEEP_NS;
        end
        send_event(item);
    endtask

    task automatic test_event_codes();
        program_registers(500_000, 2_000_000, 800_000, 900_000, 1_500_000);
        // Clock failure before any timestamp, then a timed restart
        send_event(make_event(FUNC_WORK, 0, 0, 1'b0, 1'b1));
        send_event(make_event(FUNC_RESTART, 100, 0, 1'b1, 1'b0));
        // Two write cycles, the second long enough to end warmup
        send_event(make_event(FUNC_WORK, 100, 1_000_000, 1'b1, 1'b1));
        send_event(make_event(FUNC_WORK, 100, 3_000_000, 1'b1, 1'b1));
        // Counted overrun, underrun, then skipped and counted overruns
        send_event(make_event(FUNC_WORK, 100, 3_500_000, 1'b1, 1'b1));
        send_event(make_event(FUNC_WORK, 101, 0, 1'b1, 1'b0));
        send_event(make_event(FUNC_WORK, 101, 100_000, 1'b1, 1'b0));
        send_event(make_event(FUNC_WORK, 101, 200_000, 1'b1, 1'b1));
        // Underrun by whole seconds, idle entry and a fresh timed cycle
        send_event(make_event(FUNC_WORK, 103, 200_000, 1'b1, 1'b1));
        send_event(make_event(FUNC_IDLE, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 1'b1, 1'b1));
        send_event(make_event(FUNC_WORK, 103, 300_000, 1'b1, 1'b0));
        send_event(make_event(FUNC_WORK, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 1'b0, 1'b0));
        send_event(make_event(FUNC_UNUSED, 32'hFFFF_FFFF, 30'h3FFF_FFFF, 1'b1, 1'b1));
        // Nanoseconds out of range, then time going backwards
        send_event(make_event(FUNC_WORK, 200, 30'h3FFF_FFFF, 1'b1, 1'b0));
        send_event(make_event(FUNC_WORK, 200, MAX_SLEEP_NS, 1'b1, 1'b0));
        send_event(make_event(FUNC_WORK, 199, 5, 1'b1, 1'b1));
        // Restart without a clock, then seconds wrapping round zero
        send_event(make_event(FUNC_RESTART, 0, 0, 1'b0, 1'b0));
        send_event(make_event(FUNC_WORK, 32'hFFFF_FFFF, MAX_SLEEP_NS, 1'b1, 1'b1));
        send_event(make_event(FUNC_WORK, 0, 0, 1'b1, 1'b1));
        send_event(make_event(FUNC_WORK, 0, MAX_SLEEP_NS, 1'b1, 1'b1));
    endtask

    task automatic test_warmup_by_count();
        int i;
        // Nothing exceeds the warmup delta, so only the cycle count ends it
        program_registers(MAX_SLEEP_NS, MAX_SLEEP_NS, MAX_SLEEP_NS, 0, MAX_SLEEP_NS);
        send_event(make_event(FUNC_RESTART, 7, 0, 1'b1, 1'b1));
        for (i = 1; i <= 11; i++)
            send_event(make_event(FUNC_WORK, 7, 30'(i * 1000), 1'b1, i != 5));
    endtask

    task automatic test_random_loop();
        int phase;
        logic [29:0] under_v;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: program_registers(0, 0, 0, 0, 0);
                1: program_registers(MAX_SLEEP_NS, MAX_SLEEP_NS, MAX_SLEEP_NS,
                                     MAX_SLEEP_NS, MAX_SLEEP_NS);
                default:
                begin
                    under_v = $urandom_range(100_000, 20_000_000);
                    program_registers($urandom_range(0, 999_999_999), under_v,
                                      $urandom_range(0, under_v),
                                      $urandom_range(0, 2 * under_v),
                                      $urandom_range(0, under_v));
                end
            endcase
            steady_flow = (phase == 3);
            restart_cursor();
            send_event(make_event(FUNC_RESTART, tick_sec, tick_nsec, 1'b1, 1'b0));
            repeat (180) send_random_event();
        end
        settle_block();
        steady_flow = 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_event_codes();
        test_warmup_by_count();
        test_random_loop();
        // Hold for late or stray results
        repeat (8) @(posedge clk);
        $display("checked %0d results from %0d events over %0d register settings",
                 results_checked, events_sent, settings_used);
        $display("underruns %0d, counted overruns %0d, warm results %0d, mismatches %0d",
                 underruns_seen, overruns_seen, warm_results, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Bound the run
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
design/lpm_pkg.sv
design/loop_period_monitor.sv
test/tb_loop_period_monitor.sv
